// ===== hw/rtl/sia_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg
// Sizes, widths and command codes shared by the slot index allocator.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int SLOTS      = 4096;
    localparam int VALUE_BITS = 64;

    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam int IN_IDX_W   = 16;
    localparam int IN_VAL_W   = 64;
    localparam int GRANT_W    = 12;
    localparam int READ_W     = 64;

    localparam logic [IN_IDX_W:0] SLOT_LIMIT = (IN_IDX_W + 1)'(SLOTS);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SET   = 2'd2,
        CMD_GET   = 2'd3
    } t_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/sia_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sia_if
// Command and response channels of the slot index allocator.
// ----------------------------------------------------------------------------
interface sia_cmd_if import sia_pkg::*; ();
    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [IN_IDX_W-1:0] slot_index;
    logic [IN_VAL_W-1:0] slot_value;

    modport source (output valid, output command, output slot_index, output slot_value,
                    input ready);
    modport sink   (input valid, input command, input slot_index, input slot_value,
                    output ready);
endinterface

interface sia_rsp_if import sia_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [GRANT_W-1:0] granted_index;
    logic [READ_W-1:0]  read_value;

    modport source (output valid, output ok, output granted_index, output read_value,
                    input ready);
    modport sink   (input valid, input ok, input granted_index, input read_value,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/slot_index_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slot_index_allocator_unit
// Free-list stack allocator over a fixed pool of slots, with one stored
// value per slot.
//
//   channel  dir  fields                               transaction
//   i_cmd    in   command, slot_index, slot_value      one command
//   o_rsp    out  ok, granted_index, read_value        one result per command
//
// Each transaction is a memory read, then a modify and write back.
// The next command is taken once the previous one has written back.
// After reset a sweep over all SLOTS (4096) addresses initialises the stack, map
// and value memories; no command is taken during it.
// A result waits in the output register; one further command may be read
// meanwhile and is held until the result is taken.
// ----------------------------------------------------------------------------
module slot_index_allocator_unit import sia_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sia_cmd_if.sink    i_cmd,
    sia_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_clr_addr;
    logic [CNT_W-1:0]       r_count, n_count;
    t_cmd                   r_cmd;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_in_range;
    logic [VALUE_BITS-1:0]  r_val;

    logic                   r_out_valid;
    logic                   r_ok, n_ok;
    logic [GRANT_W-1:0]     r_granted, n_granted;
    logic [READ_W-1:0]      r_rd, n_rd;

    logic                   accept, done;
    logic [CNT_W-1:0]       top_pos;

    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr, stk_wdata, stk_rd;
    logic                   map_we;
    logic [IDX_W-1:0]       map_waddr;
    logic [0:0]             map_wdata, map_rd;
    logic                   val_we;
    logic [IDX_W-1:0]       val_waddr;
    logic [VALUE_BITS-1:0]  val_wdata, val_rd;

    assign i_cmd.ready         = (r_state == ST_IDLE);
    assign accept              = i_cmd.valid && i_cmd.ready;
    assign done                = (r_state == ST_BUSY) && (!r_out_valid || o_rsp.ready);
    assign top_pos             = r_count - CNT_ONE;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.ok            = r_ok;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.read_value    = r_rd;

    sia_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (accept),
        .i_raddr (top_pos[IDX_W-1:0]),
        .o_rdata (stk_rd)
    );

    sia_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (accept),
        .i_raddr (i_cmd.slot_index[IDX_W-1:0]),
        .o_rdata (map_rd)
    );

    sia_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (accept),
        .i_raddr (i_cmd.slot_index[IDX_W-1:0]),
        .o_rdata (val_rd)
    );

    always_comb begin
        n_ok      = 1'b0;
        n_granted = '0;
        n_rd      = '0;
        n_count   = r_count;
        stk_we    = 1'b0;
        stk_waddr = r_count[IDX_W-1:0];
        stk_wdata = r_idx;
        map_we    = 1'b0;
        map_waddr = r_idx;
        map_wdata = 1'b0;
        val_we    = 1'b0;
        val_waddr = r_idx;
        val_wdata = r_val;
        if (r_state == ST_CLEAR) begin
            stk_we    = 1'b1;
            stk_waddr = r_clr_addr;
            stk_wdata = r_clr_addr;
            map_we    = 1'b1;
            map_waddr = r_clr_addr;
            val_we    = 1'b1;
            val_waddr = r_clr_addr;
            val_wdata = '0;
        end else if (done) begin
            unique case (r_cmd)
                CMD_ALLOC: begin
                    if (r_count != '0) begin
                        n_count   = top_pos;
                        map_we    = 1'b1;
                        map_waddr = stk_rd;
                        map_wdata = 1'b1;
                        n_ok      = 1'b1;
                        n_granted = GRANT_W'(stk_rd);
                    end
                end
                CMD_FREE: begin
                    if (r_in_range && map_rd[0] && (r_count < CNT_FULL)) begin
                        stk_we  = 1'b1;
                        map_we  = 1'b1;
                        n_count = r_count + CNT_ONE;
                        n_ok    = 1'b1;
                    end
                end
                CMD_SET: begin
                    if (r_in_range) begin
                        val_we = 1'b1;
                        n_ok   = 1'b1;
                    end
                end
                CMD_GET: begin
                    if (r_in_range && map_rd[0]) begin
                        n_ok = 1'b1;
                        n_rd = READ_W'(val_rd);
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == IDX_W'(SLOTS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_BUSY;
            ST_BUSY:  if (done) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= CNT_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (accept) begin
                r_cmd      <= i_cmd.command;
                r_idx      <= i_cmd.slot_index[IDX_W-1:0];
                r_in_range <= ({1'b0, i_cmd.slot_index} < SLOT_LIMIT);
                r_val      <= i_cmd.slot_value[VALUE_BITS-1:0];
            end
            if (done) begin
                r_out_valid <= 1'b1;
                r_ok        <= n_ok;
                r_granted   <= n_granted;
                r_rd        <= n_rd;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("free count above pool size");

    a_alloc_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && (r_cmd == CMD_ALLOC) && n_ok) |=> (r_count == $past(top_pos)))
        else $error("allocate did not pop the stack");

    a_no_cmd_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !accept)
        else $error("command taken during initialisation sweep");

    a_value_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_rd != '0) || (r_granted != '0))) |-> r_ok)
        else $error("result data without success");

endmodule
`default_nettype wire

// ===== hw/rtl/sia_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sia_ram
// Generic RAM, one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sia_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
